// ----- rtl/uvst_pkg.sv -----
// Shared types and constants of the UV sphere tessellator.
package uvst_pkg;

   localparam int ANGLE_BITS  = 16;
   localparam int QUAD_BITS   = ANGLE_BITS - 2;
   localparam int MAX_STACKS  = 256;
   localparam int MAX_SECTORS = 256;

   // Long division: quotient bits and remainder width of the three dividers
   localparam int QUOT_W     = 17;
   localparam int REM_W      = 26;
   localparam int DIV_STAGES = QUOT_W;

   // Sine/cosine unit
   localparam int HORNER_STEPS = 5;
   localparam int SC_LAT       = 4 + 3 * HORNER_STEPS;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [30:0] PIH_Q30 = 31'd1686629713;

   localparam logic [7:0] SIN_DIV [HORNER_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12};
   localparam logic [29:0] SIN_RECIP [HORNER_STEPS] = '{
      30'(33'h1_0000_0000 / 33'd110), 30'(33'h1_0000_0000 / 33'd72),
      30'(33'h1_0000_0000 / 33'd42),  30'(33'h1_0000_0000 / 33'd20),
      30'(33'h1_0000_0000 / 33'd6)};
   localparam logic [29:0] COS_RECIP [HORNER_STEPS] = '{
      30'(33'h1_0000_0000 / 33'd132), 30'(33'h1_0000_0000 / 33'd90),
      30'(33'h1_0000_0000 / 33'd56),  30'(33'h1_0000_0000 / 33'd30),
      30'(33'h1_0000_0000 / 33'd12)};

   // Total pipeline depth: input stage, divider, trig unit, three output stages
   localparam int TEX_FIRST = 1 + DIV_STAGES;
   localparam int LAT       = TEX_FIRST + SC_LAT + 3;

   typedef enum logic [1:0] {
      CSR_STACK_COUNT   = 2'd0,
      CSR_SECTOR_COUNT  = 2'd1,
      CSR_SPHERE_RADIUS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [30:0] sin_mag;
      logic        sin_neg;
      logic [30:0] cos_mag;
      logic        cos_neg;
   } trig_type;

   typedef struct packed {
      logic [30:0] x;
      logic [31:0] x2;
      logic [1:0]  quad;
   } sc_carry_type;

   typedef struct packed {
      logic [16:0] vertex_index;
      logic [16:0] below_index;
      logic        upper_tri_valid;
      logic        lower_tri_valid;
   } side_type;

   typedef struct packed {
      logic [16:0] u;
      logic [16:0] v;
   } tex_type;

endpackage

// ----- rtl/uvst_if.sv -----
// Request and response channel interfaces of the UV sphere tessellator.
interface uvst_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] stack_index;
   logic [8:0] sector_index;
   modport source (output valid, stack_index, sector_index, input ready);
   modport sink (input valid, stack_index, sector_index, output ready);
endinterface

interface uvst_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] pos_x;
   logic signed [16:0] pos_y;
   logic signed [16:0] pos_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;
   logic [16:0]        tex_u;
   logic [16:0]        tex_v;
   logic [16:0]        vertex_index;
   logic [16:0]        below_index;
   logic               upper_tri_valid;
   logic               lower_tri_valid;
   modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                   vertex_index, below_index, upper_tri_valid, lower_tri_valid,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                 vertex_index, below_index, upper_tri_valid, lower_tri_valid,
                 output ready);
endinterface

// ----- rtl/uvst_sincos.sv -----
// Pipelined fixed-point sine and cosine of a turn-fraction phase.
module uvst_sincos (
   input  logic                              clock,
   input  logic                              advance,
   input  logic [uvst_pkg::ANGLE_BITS-1:0]   phase,
   output uvst_pkg::trig_type                trig
);
   localparam int QB = uvst_pkg::QUAD_BITS;
   localparam int NS = uvst_pkg::HORNER_STEPS;
   localparam int NC = 3 * NS;

   logic [30:0] x1_ff;
   logic [1:0]  q1_ff;
   uvst_pkg::sc_carry_type carry_ff [0:NC];
   uvst_pkg::sc_carry_type carry_in;

   logic [62:0] ps_ff [NS];
   logic [62:0] pc_ff [NS];
   logic [31:0] vs_ff [NS];
   logic [31:0] vc_ff [NS];
   logic [61:0] ms_ff [NS];
   logic [61:0] mc_ff [NS];
   logic [30:0] ts_ff [NS];
   logic [30:0] tc_ff [NS];
   logic [30:0] ts_src [NS];
   logic [30:0] tc_src [NS];
   logic [30:0] ts_in [NS];
   logic [30:0] tc_in [NS];

   logic [61:0] fs_ff;
   logic [62:0] fc_ff;
   logic [1:0]  fq_ff;
   uvst_pkg::trig_type trig_ff;
   uvst_pkg::trig_type trig_in;

   logic [44:0] xprod;
   logic [61:0] x2prod;

   // in-quadrant angle to radians in Q30, then its square
   always_comb begin
      xprod  = 45'(phase[QB-1:0]) * 45'(uvst_pkg::PIH_Q30);
      x2prod = 62'(x1_ff) * 62'(x1_ff);
      carry_in.x    = x1_ff;
      carry_in.x2   = x2prod[61:30];
      carry_in.quad = q1_ff;
   end

   // Horner steps: multiply, reciprocal multiply, correct and subtract
   always_comb begin
      logic [29:0] q0s, q0c;
      logic [31:0] rs, rc;
      logic [30:0] qs, qc;
      for (int k = 0; k < NS; k++) begin
         ts_src[k] = (k == 0) ? uvst_pkg::Q30_ONE : ts_ff[(k == 0) ? 0 : k - 1];
         tc_src[k] = (k == 0) ? uvst_pkg::Q30_ONE : tc_ff[(k == 0) ? 0 : k - 1];
         q0s = ms_ff[k][61:32];
         q0c = mc_ff[k][61:32];
         rs  = vs_ff[k] - 32'(q0s) * 32'(uvst_pkg::SIN_DIV[k]);
         rc  = vc_ff[k] - 32'(q0c) * 32'(uvst_pkg::COS_DIV[k]);
         qs  = 31'(q0s) + ((rs >= 32'(uvst_pkg::SIN_DIV[k])) ? 31'd1 : 31'd0);
         qc  = 31'(q0c) + ((rc >= 32'(uvst_pkg::COS_DIV[k])) ? 31'd1 : 31'd0);
         ts_in[k] = uvst_pkg::Q30_ONE - qs;
         tc_in[k] = uvst_pkg::Q30_ONE - qc;
      end
   end

   // sine from x*t, cosine from 1 - x2*t/2 clamped at zero, then quadrant fold
   always_comb begin
      logic [30:0] s;
      logic [31:0] d;
      logic [30:0] c;
      s = fs_ff[60:30];
      d = fc_ff[62:31];
      c = (d >= 32'(uvst_pkg::Q30_ONE)) ? 31'd0 : 31'(32'(uvst_pkg::Q30_ONE) - d);
      case (fq_ff)
         2'd0: begin
            trig_in = '{sin_mag: s, sin_neg: 1'b0, cos_mag: c, cos_neg: 1'b0};
         end
         2'd1: begin
            trig_in = '{sin_mag: c, sin_neg: 1'b0, cos_mag: s, cos_neg: 1'b1};
         end
         2'd2: begin
            trig_in = '{sin_mag: s, sin_neg: 1'b1, cos_mag: c, cos_neg: 1'b1};
         end
         default: begin
            trig_in = '{sin_mag: c, sin_neg: 1'b1, cos_mag: s, cos_neg: 1'b0};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff <= xprod[44:QB];
         q1_ff <= phase[uvst_pkg::ANGLE_BITS-1:QB];
         carry_ff[0] <= carry_in;
         for (int n = 1; n <= NC; n++) begin
            carry_ff[n] <= carry_ff[n-1];
         end
         for (int k = 0; k < NS; k++) begin
            ps_ff[k] <= 63'(carry_ff[3*k].x2) * 63'(ts_src[k]);
            pc_ff[k] <= 63'(carry_ff[3*k].x2) * 63'(tc_src[k]);
            vs_ff[k] <= ps_ff[k][61:30];
            vc_ff[k] <= pc_ff[k][61:30];
            ms_ff[k] <= 62'(ps_ff[k][61:30]) * 62'(uvst_pkg::SIN_RECIP[k]);
            mc_ff[k] <= 62'(pc_ff[k][61:30]) * 62'(uvst_pkg::COS_RECIP[k]);
            ts_ff[k] <= ts_in[k];
            tc_ff[k] <= tc_in[k];
         end
         fs_ff   <= 62'(carry_ff[NC].x) * 62'(ts_ff[NS-1]);
         fc_ff   <= 63'(carry_ff[NC].x2) * 63'(tc_ff[NS-1]);
         fq_ff   <= carry_ff[NC].quad;
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

// ----- rtl/uv_sphere_tessellator.sv -----
// UV sphere vertex generator: grid point in, vertex, normal, UV and indices out.
//
//  channel   | dir | handshake        | contents
//  ----------+-----+------------------+-------------------------------------------
//  req_if    | in  | valid/ready      | stack_index, sector_index
//  rsp_if    | out | valid/ready      | position, normal, uv, indices, tri flags
//  APB       | in  | psel/penable     | stack_count @0, sector_count @4, radius @8
//
//  One request per cycle sustained while rsp_if is not stalled; every request gives
//  one response through 1 input stage, 17 restoring-division stages, 19 trig stages
//  and 3 output stages. The trig unit's Horner chain, three stages per series term,
//  sets the depth. Reset clears the valid bits and loads the register defaults.
//  A stalled response freezes the whole pipeline; req_if.ready drops with it.
module uv_sphere_tessellator (
   input  logic        clock,
   input  logic        reset,
   uvst_req_if.sink    req_if,
   uvst_rsp_if.source  rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int LAT   = uvst_pkg::LAT;
   localparam int DS    = uvst_pkg::DIV_STAGES;
   localparam int QW    = uvst_pkg::QUOT_W;
   localparam int RW    = uvst_pkg::REM_W;
   localparam int TEX0  = uvst_pkg::TEX_FIRST;

   // ---------------- configuration registers ----------------
   logic [8:0]  stack_count_ff;
   logic [8:0]  sector_count_ff;
   logic [15:0] radius_ff;
   logic [8:0]  wr_count;
   logic        wr_en;
   uvst_pkg::csr_index_type csr_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign csr_index = uvst_pkg::csr_index_type'(paddr[3:2]);
   assign wr_count  = pwdata[8:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff  <= 9'd16;
         sector_count_ff <= 9'd32;
         radius_ff       <= 16'd256;
      end else if (wr_en) begin
         case (csr_index)
            uvst_pkg::CSR_STACK_COUNT: begin
               // zero acts as one, above the maximum acts as the maximum
               stack_count_ff <= (wr_count == 9'd0) ? 9'd1 :
                  (wr_count > 9'(uvst_pkg::MAX_STACKS)) ? 9'(uvst_pkg::MAX_STACKS) : wr_count;
            end
            uvst_pkg::CSR_SECTOR_COUNT: begin
               sector_count_ff <= (wr_count == 9'd0) ? 9'd1 :
                  (wr_count > 9'(uvst_pkg::MAX_SECTORS)) ? 9'(uvst_pkg::MAX_SECTORS) : wr_count;
            end
            uvst_pkg::CSR_SPHERE_RADIUS: begin
               radius_ff <= pwdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         uvst_pkg::CSR_STACK_COUNT:   prdata = 32'(stack_count_ff);
         uvst_pkg::CSR_SECTOR_COUNT:  prdata = 32'(sector_count_ff);
         uvst_pkg::CSR_SPHERE_RADIUS: prdata = 32'(radius_ff);
         default:                     prdata = 32'd0;
      endcase
   end

   // ---------------- flow control ----------------
   // advance the whole pipeline unless a finished response is held
   logic           advance;
   logic [LAT-1:0] vld_ff;

   assign advance      = !vld_ff[LAT-1] || rsp_if.ready;
   assign req_if.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_if.valid};
      end
   end

   // ---------------- input stage: clamp indices ----------------
   logic [8:0] a_i_ff, a_j_ff;
   logic [8:0] a_i_in, a_j_in;

   assign a_i_in = (req_if.stack_index > stack_count_ff) ? stack_count_ff : req_if.stack_index;
   assign a_j_in = (req_if.sector_index > sector_count_ff) ? sector_count_ff : req_if.sector_index;

   always_ff @(posedge clock) begin
      if (advance) begin
         a_i_ff <= a_i_in;
         a_j_ff <= a_j_in;
      end
   end

   // indices and triangle flags ride alongside the datapath
   uvst_pkg::side_type side_ff [1:LAT-1];
   uvst_pkg::side_type side_in;

   always_comb begin
      logic [16:0] vi;
      logic        in_grid;
      vi = 17'(19'(a_i_ff) * 19'({1'b0, sector_count_ff} + 10'd1)) + 17'(a_j_ff);
      in_grid = (a_i_ff < stack_count_ff) && (a_j_ff < sector_count_ff);
      side_in.vertex_index    = vi;
      side_in.below_index     = vi + 17'(sector_count_ff) + 17'd1;
      side_in.upper_tri_valid = in_grid && (a_i_ff != 9'd0);
      side_in.lower_tri_valid = in_grid && (a_i_ff != stack_count_ff - 9'd1);
   end

   // ---------------- restoring dividers, one quotient bit per stage ----------------
   // stack phase:  (i*2^16 + S) / 2S
   // sector phase and u: (j*2^16 + N/2) / N
   // v:            (i*2^16 + S/2) / S
   logic [RW-1:0] rs_ff [DS];
   logic [RW-1:0] rc_ff [DS];
   logic [RW-1:0] rv_ff [DS];
   logic [QW-1:0] qs_ff [DS];
   logic [QW-1:0] qc_ff [DS];
   logic [QW-1:0] qv_ff [DS];
   logic [RW-1:0] rs_in [DS];
   logic [RW-1:0] rc_in [DS];
   logic [RW-1:0] rv_in [DS];
   logic [QW-1:0] qs_in [DS];
   logic [QW-1:0] qc_in [DS];
   logic [QW-1:0] qv_in [DS];
   logic [9:0]    dsor_s, dsor_c, dsor_v;

   assign dsor_s = {stack_count_ff, 1'b0};
   assign dsor_c = {1'b0, sector_count_ff};
   assign dsor_v = {1'b0, stack_count_ff};

   function automatic logic [RW:0] div_step(input logic [RW-1:0] rem, input logic [RW-1:0] dsh);
      if (rem >= dsh) begin
         return {1'b1, rem - dsh};
      end
      return {1'b0, rem};
   endfunction

   always_comb begin
      logic [RW-1:0] rs, rc, rv;
      logic [QW-1:0] qs, qc, qv;
      logic [RW:0]   st_s, st_c, st_v;
      for (int s = 0; s < DS; s++) begin
         if (s == 0) begin
            rs = RW'({a_i_ff, 16'd0}) + RW'(stack_count_ff);
            rc = RW'({a_j_ff, 16'd0}) + RW'(sector_count_ff[8:1]);
            rv = RW'({a_i_ff, 16'd0}) + RW'(stack_count_ff[8:1]);
            qs = '0;
            qc = '0;
            qv = '0;
         end else begin
            rs = rs_ff[(s == 0) ? 0 : s - 1];
            rc = rc_ff[(s == 0) ? 0 : s - 1];
            rv = rv_ff[(s == 0) ? 0 : s - 1];
            qs = qs_ff[(s == 0) ? 0 : s - 1];
            qc = qc_ff[(s == 0) ? 0 : s - 1];
            qv = qv_ff[(s == 0) ? 0 : s - 1];
         end
         st_s = div_step(rs, RW'(dsor_s) << (QW - 1 - s));
         st_c = div_step(rc, RW'(dsor_c) << (QW - 1 - s));
         st_v = div_step(rv, RW'(dsor_v) << (QW - 1 - s));
         qs[QW-1-s] = st_s[RW];
         qc[QW-1-s] = st_c[RW];
         qv[QW-1-s] = st_v[RW];
         rs_in[s] = st_s[RW-1:0];
         rc_in[s] = st_c[RW-1:0];
         rv_in[s] = st_v[RW-1:0];
         qs_in[s] = qs;
         qc_in[s] = qc;
         qv_in[s] = qv;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DS; s++) begin
            rs_ff[s] <= rs_in[s];
            rc_ff[s] <= rc_in[s];
            rv_ff[s] <= rv_in[s];
            qs_ff[s] <= qs_in[s];
            qc_ff[s] <= qc_in[s];
            qv_ff[s] <= qv_in[s];
         end
      end
   end

   // ---------------- phases and trig ----------------
   logic [uvst_pkg::ANGLE_BITS-1:0] stack_phase, sector_phase;
   uvst_pkg::trig_type st_trig, se_trig;

   assign stack_phase  = uvst_pkg::ANGLE_BITS'(1 << uvst_pkg::QUAD_BITS)
                         - qs_ff[DS-1][uvst_pkg::ANGLE_BITS-1:0];
   assign sector_phase = qc_ff[DS-1][uvst_pkg::ANGLE_BITS-1:0];

   uvst_sincos u_stack_trig (
      .clock   (clock),
      .advance (advance),
      .phase   (stack_phase),
      .trig    (st_trig)
   );

   uvst_sincos u_sector_trig (
      .clock   (clock),
      .advance (advance),
      .phase   (sector_phase),
      .trig    (se_trig)
   );

   uvst_pkg::tex_type tex_ff [TEX0:LAT-1];

   // ---------------- output stages ----------------
   logic [61:0] f1_px_ff, f1_py_ff;
   logic [46:0] f1_pz_ff;
   logic [15:0] f1_nz_ff;
   logic        f1_nx_neg_ff, f1_ny_neg_ff, f1_nz_neg_ff;
   logic [31:0] px_round, py_round;
   logic [16:0] nx_round, ny_round, pz_round;
   logic [47:0] f2_px_ff, f2_py_ff;
   logic [16:0] f2_pz_ff;
   logic [15:0] f2_nx_ff, f2_ny_ff, f2_nz_ff;
   logic        f2_nx_neg_ff, f2_ny_neg_ff, f2_nz_neg_ff;
   logic [16:0] px_mag, py_mag;
   logic [32:0] nz_sum;
   logic [62:0] px_sum, py_sum, nxs, nys;
   logic [47:0] pz_sum;
   logic [48:0] px_fin, py_fin;

   logic signed [16:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [15:0] norm_x_ff, norm_y_ff, norm_z_ff;

   always_comb begin
      nz_sum   = 33'(st_trig.sin_mag) + 33'h8000;
      px_sum   = 63'(f1_px_ff) + 63'h2000_0000;
      py_sum   = 63'(f1_py_ff) + 63'h2000_0000;
      nxs      = 63'(f1_px_ff) + (63'd1 << 45);
      nys      = 63'(f1_py_ff) + (63'd1 << 45);
      pz_sum   = 48'(f1_pz_ff) + 48'h2000_0000;
      px_round = px_sum[61:30];
      py_round = py_sum[61:30];
      nx_round = nxs[62:46];
      ny_round = nys[62:46];
      pz_round = pz_sum[46:30];
      px_fin   = 49'(f2_px_ff) + 49'h2000_0000;
      py_fin   = 49'(f2_py_ff) + 49'h2000_0000;
      px_mag   = px_fin[46:30];
      py_mag   = py_fin[46:30];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[1] <= side_in;
         for (int n = 2; n < LAT; n++) begin
            side_ff[n] <= side_ff[n-1];
         end
         tex_ff[TEX0] <= '{u: qc_ff[DS-1], v: qv_ff[DS-1]};
         for (int n = TEX0 + 1; n < LAT; n++) begin
            tex_ff[n] <= tex_ff[n-1];
         end

         // trig products
         f1_px_ff     <= 62'(st_trig.cos_mag) * 62'(se_trig.cos_mag);
         f1_py_ff     <= 62'(st_trig.cos_mag) * 62'(se_trig.sin_mag);
         f1_pz_ff     <= 47'(radius_ff) * 47'(st_trig.sin_mag);
         f1_nz_ff     <= nz_sum[31:16];
         f1_nx_neg_ff <= st_trig.cos_neg ^ se_trig.cos_neg;
         f1_ny_neg_ff <= st_trig.cos_neg ^ se_trig.sin_neg;
         f1_nz_neg_ff <= st_trig.sin_neg;

         // round to Q30, scale by radius; round the normals
         f2_px_ff     <= 48'(radius_ff) * 48'(px_round);
         f2_py_ff     <= 48'(radius_ff) * 48'(py_round);
         f2_pz_ff     <= pz_round;
         f2_nx_ff     <= nx_round[15:0];
         f2_ny_ff     <= ny_round[15:0];
         f2_nz_ff     <= f1_nz_ff;
         f2_nx_neg_ff <= f1_nx_neg_ff;
         f2_ny_neg_ff <= f1_ny_neg_ff;
         f2_nz_neg_ff <= f1_nz_neg_ff;

         // apply signs; a zero magnitude stays positive
         pos_x_ff  <= $signed(f2_nx_neg_ff ? 17'd0 - px_mag : px_mag);
         pos_y_ff  <= $signed(f2_ny_neg_ff ? 17'd0 - py_mag : py_mag);
         pos_z_ff  <= $signed(f2_nz_neg_ff ? 17'd0 - f2_pz_ff : f2_pz_ff);
         norm_x_ff <= $signed(f2_nx_neg_ff ? 16'd0 - f2_nx_ff : f2_nx_ff);
         norm_y_ff <= $signed(f2_ny_neg_ff ? 16'd0 - f2_ny_ff : f2_ny_ff);
         norm_z_ff <= $signed(f2_nz_neg_ff ? 16'd0 - f2_nz_ff : f2_nz_ff);
      end
   end

   assign rsp_if.valid           = vld_ff[LAT-1];
   assign rsp_if.pos_x           = pos_x_ff;
   assign rsp_if.pos_y           = pos_y_ff;
   assign rsp_if.pos_z           = pos_z_ff;
   assign rsp_if.norm_x          = norm_x_ff;
   assign rsp_if.norm_y          = norm_y_ff;
   assign rsp_if.norm_z          = norm_z_ff;
   assign rsp_if.tex_u           = tex_ff[LAT-1].u;
   assign rsp_if.tex_v           = tex_ff[LAT-1].v;
   assign rsp_if.vertex_index    = side_ff[LAT-1].vertex_index;
   assign rsp_if.below_index     = side_ff[LAT-1].below_index;
   assign rsp_if.upper_tri_valid = side_ff[LAT-1].upper_tri_valid;
   assign rsp_if.lower_tri_valid = side_ff[LAT-1].lower_tri_valid;

endmodule

// ----- rtl/uvst_checker.sv -----
// Port-level assertions for the UV sphere tessellator and their binding.
module uvst_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [16:0] pos_x,
   input logic [16:0]        tex_v,
   input logic [16:0]        vertex_index,
   input logic [16:0]        below_index,
   input logic               upper_tri_valid
);

   // a held response stays valid and keeps its vertex index and x position
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(vertex_index) && $stable(pos_x))
      else $error("response changed while stalled");

   // an empty output stage never blocks requests
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_below_differs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> below_index != vertex_index)
      else $error("below index equals vertex index");

   // an upper triangle needs a row below the pole, so v is nonzero
   a_upper_v: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && upper_tri_valid |-> tex_v != 17'd0)
      else $error("upper triangle on the top row");

endmodule

bind uv_sphere_tessellator uvst_checker u_uvst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .pos_x           (rsp_if.pos_x),
   .tex_v           (rsp_if.tex_v),
   .vertex_index    (rsp_if.vertex_index),
   .below_index     (rsp_if.below_index),
   .upper_tri_valid (rsp_if.upper_tri_valid)
);
